// ===== hdl/tlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tlfs_pkg
// Shared types and constants of the three-level feedback scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfs_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int NUM_LEVELS = 3;
    localparam int SLOT_W     = 6;
    localparam int TICK_W     = 7;
    localparam int CNT_W      = 4;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // request codes
    localparam logic [1:0] REQ_ADMIT  = 2'd0;
    localparam logic [1:0] REQ_WAKE   = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_REMOVE = 2'd3;

    // run status after a tick
    localparam logic [1:0] RST_RUN   = 2'd0;
    localparam logic [1:0] RST_SLEEP = 2'd1;

    // error codes
    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_QUEUED = 2'd1;
    localparam logic [1:0] ERR_NOTQ   = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_SLICE0 = 2'd0;
    localparam logic [1:0] CFG_SLICE1 = 2'd1;
    localparam logic [1:0] CFG_SLICE2 = 2'd2;
    localparam logic [1:0] CFG_BOOST  = 2'd3;

    typedef enum logic [2:0] {
        Q_NONE   = 3'd0,
        Q_APPEND = 3'd1,
        Q_REMOVE = 3'd2,
        Q_WAKE   = 3'd3,
        Q_HEAD   = 3'd4,
        Q_PICK   = 3'd5
    } qcmd_t;

    typedef struct packed {
        logic              occ;
        logic [SLOT_W-1:0] slot;
        logic              run;
        logic [TICK_W-1:0] ticks;
    } cell_t;

    // control from the sequencer to one queue
    typedef struct packed {
        qcmd_t             cmd;
        logic [SLOT_W-1:0] key;
        logic              app_run;
        logic              head_run;
        logic [TICK_W-1:0] head_ticks;
    } qctl_t;

    // status from one queue
    typedef struct packed {
        logic              hit;
        logic              any_run;
        logic [SLOT_W-1:0] pick_slot;
        logic [TICK_W-1:0] head_ticks;
    } qstat_t;

endpackage

`default_nettype wire

// ===== hdl/tlfs_cell.sv =====
// ----------------------------------------------------------------------------
// tlfs_cell
// One queue position: holds a slot, its runnable mark and tick count.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfs_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            is_head,
    input  wire tlfs_pkg::qctl_t ctl,
    input  wire logic            left_occ,
    input  wire logic            seen_in,
    input  wire logic            runseen_in,
    input  wire tlfs_pkg::cell_t right_data,
    input  wire tlfs_pkg::cell_t head_data,
    input  wire tlfs_pkg::cell_t pick_data,
    output tlfs_pkg::cell_t      data,
    output logic                 seen_out,
    output logic                 runseen_out,
    output logic                 sel
);
    import tlfs_pkg::*;

    cell_t data_reg, data_next;
    logic  match;

    assign data        = data_reg;
    assign match       = data_reg.occ && (data_reg.slot == ctl.key);
    assign seen_out    = seen_in | match;
    assign runseen_out = runseen_in | (data_reg.occ & data_reg.run);
    // first runnable entry of the queue
    assign sel         = data_reg.occ & data_reg.run & ~runseen_in;

    always_comb begin
        data_next = data_reg;
        case (ctl.cmd)
            Q_REMOVE: begin
                if (seen_in || match) data_next = right_data;
            end
            Q_APPEND: begin
                if (!data_reg.occ && left_occ) begin
                    data_next.occ   = 1'b1;
                    data_next.slot  = ctl.key;
                    data_next.run   = ctl.app_run;
                    data_next.ticks = '0;
                end
            end
            Q_WAKE: begin
                if (match) data_next.run = 1'b1;
            end
            Q_HEAD: begin
                if (is_head) begin
                    data_next.run   = ctl.head_run;
                    data_next.ticks = ctl.head_ticks;
                end
            end
            Q_PICK: begin
                if (is_head) data_next = pick_data;
                else if (sel) data_next = head_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg.occ <= 1'b0;
            data_reg.run <= 1'b0;
        end else begin
            data_reg.occ <= data_next.occ;
            data_reg.run <= data_next.run;
        end
        data_reg.slot  <= data_next.slot;
        data_reg.ticks <= data_next.ticks;
    end

endmodule

`default_nettype wire

// ===== hdl/tlfs_queue.sv =====
// ----------------------------------------------------------------------------
// tlfs_queue
// One level's ordered queue as a row of cells; entries stay packed at the head.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfs_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tlfs_pkg::qctl_t ctl,
    output tlfs_pkg::qstat_t     stat
);
    import tlfs_pkg::*;

    cell_t data [NUM_SLOTS];
    cell_t right [NUM_SLOTS];
    logic  seen [NUM_SLOTS+1];
    logic  runseen [NUM_SLOTS+1];
    logic  locc [NUM_SLOTS];
    logic  sel [NUM_SLOTS];
    cell_t pick_data;

    assign seen[0]    = 1'b0;
    assign runseen[0] = 1'b0;

    for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
        if (i == NUM_SLOTS - 1) begin : g_last
            assign right[i] = '0;
        end else begin : g_mid
            assign right[i] = data[i+1];
        end
        if (i == 0) begin : g_first
            assign locc[i] = 1'b1;
        end else begin : g_rest
            assign locc[i] = data[i-1].occ;
        end
        tlfs_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .is_head     (i == 0),
            .ctl         (ctl),
            .left_occ    (locc[i]),
            .seen_in     (seen[i]),
            .runseen_in  (runseen[i]),
            .right_data  (right[i]),
            .head_data   (data[0]),
            .pick_data   (pick_data),
            .data        (data[i]),
            .seen_out    (seen[i+1]),
            .runseen_out (runseen[i+1]),
            .sel         (sel[i])
        );
    end

    always_comb begin
        pick_data = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (sel[i]) pick_data = pick_data | data[i];
        end
    end

    assign stat.hit        = seen[NUM_SLOTS];
    assign stat.any_run    = runseen[NUM_SLOTS];
    assign stat.pick_slot  = pick_data.slot;
    assign stat.head_ticks = data[0].ticks;

endmodule

`default_nettype wire

// ===== hdl/three_level_feedback_scheduler.sv =====
// ----------------------------------------------------------------------------
// three_level_feedback_scheduler
// Three-level feedback task scheduler built from rows of queue cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests come in on the s_ channel (valid/ready): admit, wake, remove a
//   slot, or a tick report for the running task. Each request gives exactly
//   one result word on the m_ channel: the task to run next, its level and
//   an error code.
//   Each request passes through the find, update and pick steps, with an
//   append step before pick when it appends to a queue tail (admit, sleep,
//   demotion or boost). One request at a time: no new request is taken
//   until the pick pass over the rows is done.
//   A finished result sits in the output register; the next request is taken
//   while it waits, and the pick step holds until the output register frees.
//   Config writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once.
//   The user must make them only while the block is idle (not enforced).
//   Reset (aresetn low, synchronous) empties all queues, clears the running
//   task and restores the default slices and boost limit.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_feedback_scheduler (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_req_type,
    input  wire logic [tlfs_pkg::SLOT_W-1:0] s_slot,
    input  wire logic [1:0]                  s_run_status,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_run_valid,
    output logic [tlfs_pkg::SLOT_W-1:0]      m_run_slot,
    output logic [1:0]                       m_run_level,
    output logic [1:0]                       m_error_code,
    input  wire logic                        cfg_wr_en,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [tlfs_pkg::TICK_W-1:0] cfg_wdata
);
    import tlfs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_FIND   = 5'b00010,
        ST_EXEC   = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_PICK   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]        req_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [1:0]        rst_reg;
    logic [1:0]        err_reg, err_next;
    logic [2:0]        hit_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic [1:0]        app_lvl_reg, app_lvl_next;
    logic              app_run_reg, app_run_next;

    logic [SLOT_W-1:0] cur_slot_reg, cur_slot_next;
    logic [1:0]        cur_lvl_reg, cur_lvl_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [CNT_W-1:0]  slice_cnt_reg, slice_cnt_next;

    logic [CNT_W-1:0]  slice0_reg, slice1_reg, slice2_reg;
    logic [TICK_W-1:0] boost_reg;

    logic              out_valid_reg;
    logic              out_run_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [1:0]        out_lvl_reg;
    logic [1:0]        out_err_reg;

    qctl_t  ctl [NUM_LEVELS];
    qstat_t stat [NUM_LEVELS];
    qcmd_t  cmd [NUM_LEVELS];
    logic [SLOT_W-1:0] key;
    logic              head_run;
    logic [TICK_W-1:0] head_ticks;

    logic              queued;
    logic [1:0]        hit_lvl;
    logic [TICK_W-1:0] t_new;
    logic [CNT_W-1:0]  sc_new;
    logic [CNT_W-1:0]  slice_cur;
    logic              out_free;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = out_valid_reg;
    assign m_run_valid  = out_run_reg;
    assign m_run_slot   = out_slot_reg;
    assign m_run_level  = out_lvl_reg;
    assign m_error_code = out_err_reg;
    assign out_free     = !out_valid_reg || m_ready;

    assign key     = (req_reg == REQ_TICK) ? cur_slot_reg : slot_reg;
    assign queued  = |hit_reg;
    assign hit_lvl = hit_reg[0] ? 2'd0 : (hit_reg[1] ? 2'd1 : 2'd2);
    assign t_new   = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign sc_new  = (slice_cnt_reg == CNT_MAX) ? slice_cnt_reg : slice_cnt_reg + 1'b1;

    always_comb begin
        case (cur_lvl_reg)
            2'd0:    slice_cur = slice0_reg;
            2'd1:    slice_cur = slice1_reg;
            default: slice_cur = slice2_reg;
        endcase
    end

    for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_q
        assign ctl[l].cmd        = cmd[l];
        assign ctl[l].key        = key;
        assign ctl[l].app_run    = app_run_reg;
        assign ctl[l].head_run   = head_run;
        assign ctl[l].head_ticks = head_ticks;
        tlfs_queue u_queue (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl[l]),
            .stat    (stat[l])
        );
    end

    always_comb begin
        state_next     = state_reg;
        err_next       = err_reg;
        app_lvl_next   = app_lvl_reg;
        app_run_next   = app_run_reg;
        cur_slot_next  = cur_slot_reg;
        cur_lvl_next   = cur_lvl_reg;
        cur_valid_next = cur_valid_reg;
        slice_cnt_next = slice_cnt_reg;
        head_run       = 1'b1;
        head_ticks     = t_new;
        for (int l = 0; l < NUM_LEVELS; l++) cmd[l] = Q_NONE;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_FIND;
            end
            ST_FIND: begin
                err_next   = ERR_OK;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_PICK;
                case (req_reg)
                    REQ_ADMIT: begin
                        if (queued) begin
                            err_next = ERR_QUEUED;
                        end else begin
                            app_run_next = 1'b1;
                            app_lvl_next = 2'd0;
                            state_next   = ST_APPEND;
                        end
                    end
                    REQ_WAKE: begin
                        if (!queued) err_next = ERR_NOTQ;
                        else cmd[hit_lvl] = Q_WAKE;
                    end
                    REQ_REMOVE: begin
                        if (!queued) begin
                            err_next = ERR_NOTQ;
                        end else begin
                            cmd[hit_lvl] = Q_REMOVE;
                            if (cur_valid_reg && cur_slot_reg == slot_reg)
                                cur_valid_next = 1'b0;
                        end
                    end
                    default: begin
                        if (!cur_valid_reg) begin
                            err_next = ERR_NOTQ;
                        end else begin
                            slice_cnt_next = sc_new;
                            if (rst_reg == RST_RUN) begin
                                if (sc_new >= slice_cur) begin
                                    cur_valid_next = 1'b0;
                                    app_run_next   = 1'b1;
                                    if (cur_lvl_reg != 2'd2) begin
                                        cmd[cur_lvl_reg] = Q_REMOVE;
                                        app_lvl_next     = cur_lvl_reg + 1'b1;
                                        state_next       = ST_APPEND;
                                    end else if (t_new >= boost_reg) begin
                                        cmd[cur_lvl_reg] = Q_REMOVE;
                                        app_lvl_next     = 2'd0;
                                        state_next       = ST_APPEND;
                                    end else begin
                                        cmd[cur_lvl_reg] = Q_HEAD;
                                    end
                                end else begin
                                    cmd[cur_lvl_reg] = Q_HEAD;
                                end
                            end else if (rst_reg == RST_SLEEP) begin
                                cmd[cur_lvl_reg] = Q_REMOVE;
                                app_lvl_next     = cur_lvl_reg;
                                app_run_next     = 1'b0;
                                cur_valid_next   = 1'b0;
                                state_next       = ST_APPEND;
                            end else begin
                                // exit: stays queued, loses its runnable mark
                                cmd[cur_lvl_reg] = Q_HEAD;
                                head_run         = 1'b0;
                                cur_valid_next   = 1'b0;
                            end
                        end
                    end
                endcase
            end
            ST_APPEND: begin
                cmd[app_lvl_reg] = Q_APPEND;
                state_next       = ST_PICK;
            end
            ST_PICK: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (!cur_valid_reg) begin
                        if (stat[0].any_run) begin
                            cmd[0] = Q_PICK;
                            cur_slot_next  = stat[0].pick_slot;
                            cur_lvl_next   = 2'd0;
                            cur_valid_next = 1'b1;
                            slice_cnt_next = '0;
                        end else if (stat[1].any_run) begin
                            cmd[1] = Q_PICK;
                            cur_slot_next  = stat[1].pick_slot;
                            cur_lvl_next   = 2'd1;
                            cur_valid_next = 1'b1;
                            slice_cnt_next = '0;
                        end else if (stat[2].any_run) begin
                            cmd[2] = Q_PICK;
                            cur_slot_next  = stat[2].pick_slot;
                            cur_lvl_next   = 2'd2;
                            cur_valid_next = 1'b1;
                            slice_cnt_next = '0;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_valid_reg <= 1'b0;
            cur_slot_reg  <= '0;
            cur_lvl_reg   <= '0;
            slice_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            slice0_reg    <= CNT_W'(1);
            slice1_reg    <= CNT_W'(2);
            slice2_reg    <= CNT_W'(8);
            boost_reg     <= TICK_W'(50);
        end else begin
            state_reg     <= state_next;
            cur_valid_reg <= cur_valid_next;
            cur_slot_reg  <= cur_slot_next;
            cur_lvl_reg   <= cur_lvl_next;
            slice_cnt_reg <= slice_cnt_next;
            if (state_reg == ST_PICK && out_free) out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SLICE0: slice0_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_SLICE1: slice1_reg <= cfg_wdata[CNT_W-1:0];
                    CFG_SLICE2: slice2_reg <= cfg_wdata[CNT_W-1:0];
                    default:    boost_reg  <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg  <= s_req_type;
            slot_reg <= s_slot;
            rst_reg  <= s_run_status;
        end
        if (state_reg == ST_FIND) begin
            hit_reg   <= {stat[2].hit, stat[1].hit, stat[0].hit};
            ticks_reg <= stat[cur_lvl_reg].head_ticks;
        end
        err_reg     <= err_next;
        app_lvl_reg <= app_lvl_next;
        app_run_reg <= app_run_next;
        if (state_reg == ST_PICK && out_free) begin
            out_run_reg  <= cur_valid_next;
            out_slot_reg <= cur_valid_next ? cur_slot_next : '0;
            out_lvl_reg  <= cur_valid_next ? cur_lvl_next : 2'd0;
            out_err_reg  <= err_reg;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_three_level_feedback_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_three_level_feedback_scheduler
// Self-checking bench: a behavioral scheduler model predicts every result
// word; directed cases, then random request streams under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_three_level_feedback_scheduler;
    import tlfs_pkg::*;

    localparam int LIMIT = 400000;

    typedef struct packed {
        logic              rv;
        logic [SLOT_W-1:0] rs;
        logic [1:0]        rl;
        logic [1:0]        err;
    } sched_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [SLOT_W-1:0] s_slot = '0;
    logic [1:0] s_run_status = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_run_valid;
    logic [SLOT_W-1:0] m_run_slot;
    logic [1:0] m_run_level;
    logic [1:0] m_error_code;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [TICK_W-1:0] cfg_wdata = '0;

    three_level_feedback_scheduler i_dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // scheduler model state
    int unsigned q_ent [NUM_LEVELS][NUM_SLOTS];
    int unsigned q_len [NUM_LEVELS];
    bit          mk_run [NUM_SLOTS];
    bit          mk_q [NUM_SLOTS];
    int unsigned t_lvl [NUM_SLOTS];
    int unsigned t_ticks [NUM_SLOTS];
    int unsigned cur_slot;
    bit          cur_valid;
    int unsigned slice_cnt;
    int unsigned slice_reg [3];
    int unsigned boost_reg;

    sched_word_t pending_words[$];
    int errors = 0;
    int cycles = 0;
    bit sink_stall_en = 1'b1;
    int unsigned sink_wait = 0;

    function automatic void q_del(int unsigned lv, int unsigned s);
        int unsigned i;
        i = 0;
        while (i < q_len[lv] && q_ent[lv][i] != s) i++;
        if (i >= q_len[lv]) return;
        for (int unsigned j = i; j + 1 < q_len[lv]; j++) q_ent[lv][j] = q_ent[lv][j+1];
        q_len[lv]--;
    endfunction

    function automatic void q_add(int unsigned lv, int unsigned s);
        if (q_len[lv] >= NUM_SLOTS) return;
        q_ent[lv][q_len[lv]] = s;
        q_len[lv]++;
        t_lvl[s] = lv;
        t_ticks[s] = 0;
    endfunction

    function automatic void pick_next();
        int unsigned s;
        for (int unsigned lv = 0; lv < NUM_LEVELS; lv++) begin
            for (int unsigned i = 0; i < q_len[lv]; i++) begin
                s = q_ent[lv][i];
                if (mk_run[s]) begin
                    q_ent[lv][i] = q_ent[lv][0];
                    q_ent[lv][0] = s;
                    cur_slot = s;
                    cur_valid = 1'b1;
                    slice_cnt = 0;
                    return;
                end
            end
        end
    endfunction

    function automatic sched_word_t sched_predict(logic [1:0] req, int unsigned slot,
                                                  logic [1:0] st);
        sched_word_t w;
        int unsigned lv, sl;
        w = '0;
        if (req == REQ_ADMIT) begin
            if (mk_q[slot] || q_len[0] >= NUM_SLOTS) w.err = ERR_QUEUED;
            else begin
                q_add(0, slot);
                mk_q[slot] = 1;
                mk_run[slot] = 1;
            end
        end else if (req == REQ_WAKE || req == REQ_REMOVE) begin
            if (!mk_q[slot]) w.err = ERR_NOTQ;
            else if (req == REQ_WAKE) mk_run[slot] = 1;
            else begin
                q_del(t_lvl[slot], slot);
                mk_q[slot] = 0;
                mk_run[slot] = 0;
                if (cur_valid && cur_slot == slot) cur_valid = 0;
            end
        end else begin
            if (!cur_valid) w.err = ERR_NOTQ;
            else begin
                lv = t_lvl[cur_slot];
                if (t_ticks[cur_slot] < 127) t_ticks[cur_slot]++;
                if (slice_cnt < 15) slice_cnt++;
                if (st == RST_RUN) begin
                    sl = slice_reg[lv] == 0 ? 1 : slice_reg[lv];
                    if (slice_cnt >= sl) begin
                        if (lv < 2) begin
                            q_del(lv, cur_slot);
                            q_add(lv + 1, cur_slot);
                        end else if (t_ticks[cur_slot] >= boost_reg) begin
                            q_del(lv, cur_slot);
                            q_add(0, cur_slot);
                        end
                        cur_valid = 0;
                    end
                end else if (st == RST_SLEEP) begin
                    mk_run[cur_slot] = 0;
                    q_del(lv, cur_slot);
                    q_add(lv, cur_slot);
                    cur_valid = 0;
                end else begin
                    mk_run[cur_slot] = 0;
                    cur_valid = 0;
                end
            end
        end
        if (!cur_valid) pick_next();
        if (cur_valid) begin
            w.rv = 1;
            w.rs = cur_slot[SLOT_W-1:0];
            w.rl = t_lvl[cur_slot][1:0];
        end
        return w;
    endfunction

    task automatic send_request(logic [1:0] req, logic [SLOT_W-1:0] slot, logic [1:0] st);
        repeat ($urandom_range(0, 12) * $urandom_range(0, 1)) @(posedge aclk);
        pending_words.push_back(sched_predict(req, slot, st));
        s_valid <= 1'b1;
        s_req_type <= req;
        s_slot <= slot;
        s_run_status <= st;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, int unsigned val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[TICK_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BOOST) boost_reg = val & 127;
        else slice_reg[idx] = val & 15;
    endtask

    // result checker and sink stalls
    always @(posedge aclk) begin
        sched_word_t exp_w;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word run=%b slot=%0d lvl=%0d err=%0d", $realtime,
                         m_run_valid, m_run_slot, m_run_level, m_error_code);
                errors <= errors + 1;
            end else begin
                exp_w = pending_words.pop_front();
                if (exp_w !== {m_run_valid, m_run_slot, m_run_level, m_error_code}) begin
                    $display("%0t: expected run=%b slot=%0d lvl=%0d err=%0d, got run=%b slot=%0d lvl=%0d err=%0d",
                             $realtime, exp_w.rv, exp_w.rs, exp_w.rl, exp_w.err,
                             m_run_valid, m_run_slot, m_run_level, m_error_code);
                    errors <= errors + 1;
                end
            end
        end
        // per word: hold ready low for a drawn number of cycles once it shows up
        if (!sink_stall_en) begin
            m_ready <= 1'b1;
        end else if (m_valid && m_ready) begin
            m_ready   <= 1'b0;
            sink_wait <= $urandom_range(0, 12);
        end else if (m_valid && !m_ready) begin
            if (sink_wait == 0) m_ready <= 1'b1;
            else sink_wait <= sink_wait - 1;
        end
    end

    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("three_level_feedback_scheduler: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(REQ_TICK, 0, RST_RUN);     // no running task
        send_request(REQ_WAKE, 63, RST_RUN);    // unqueued wake
        send_request(REQ_REMOVE, 5, RST_RUN);   // unqueued remove
        send_request(REQ_ADMIT, 0, RST_RUN);
        send_request(REQ_ADMIT, 63, RST_RUN);
        send_request(REQ_ADMIT, 63, RST_RUN);   // already queued
        send_request(REQ_TICK, 0, RST_RUN);     // demote after level 0 slice
        send_request(REQ_TICK, 0, RST_RUN);
        send_request(REQ_TICK, 0, RST_SLEEP);
        send_request(REQ_WAKE, 0, RST_RUN);
        send_request(REQ_TICK, 0, 2'd2);        // exit
        send_request(REQ_TICK, 0, 2'd3);        // status 3 acts as exit
        send_request(REQ_TICK, 0, RST_RUN);
        send_request(REQ_WAKE, 0, RST_RUN);
        send_request(REQ_WAKE, 63, RST_RUN);
        send_request(REQ_ADMIT, 21, RST_RUN);   // no preemption
        send_request(REQ_REMOVE, 63, RST_RUN);
        send_request(REQ_REMOVE, 0, RST_RUN);
        send_request(REQ_REMOVE, 21, RST_RUN);
        send_request(REQ_TICK, 42, RST_RUN);
    endtask

    task automatic test_random(int n, int unsigned span);
        int r;
        logic [SLOT_W-1:0] sl;
        logic [1:0] st;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            sl = SLOT_W'($urandom_range(0, span));
            st = 2'($urandom_range(0, 3));
            if (r < 20) send_request(REQ_ADMIT, sl, st);
            else if (r < 30) send_request(REQ_WAKE, sl, st);
            else if (r < 38) send_request(REQ_REMOVE, sl, st);
            else if (r < 97) begin
                sl = SLOT_W'($urandom);
                st = ($urandom_range(0, 99) < 85) ? RST_RUN : 2'($urandom_range(1, 3));
                send_request(REQ_TICK, sl, st);
            end else send_request(2'($urandom), SLOT_W'($urandom), 2'($urandom));
        end
    endtask

    task automatic test_full_queue();
        // admit every slot not yet queued to level 0, then churn
        for (int s = 0; s < NUM_SLOTS; s++) send_request(REQ_ADMIT, SLOT_W'(s), RST_RUN);
        send_request(REQ_ADMIT, 7, RST_RUN);
        test_random(40, 63);
        for (int s = 0; s < NUM_SLOTS; s++) send_request(REQ_REMOVE, SLOT_W'(s), RST_RUN);
    endtask

    initial begin
        for (int l = 0; l < NUM_LEVELS; l++) q_len[l] = 0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            mk_run[s] = 0; mk_q[s] = 0; t_lvl[s] = 0; t_ticks[s] = 0;
        end
        cur_slot = 0; cur_valid = 0; slice_cnt = 0;
        slice_reg[0] = 1; slice_reg[1] = 2; slice_reg[2] = 8; boost_reg = 50;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        drain();
        test_random(60, 7);
        write_cfg(CFG_SLICE0, 15);
        write_cfg(CFG_SLICE1, 15);
        write_cfg(CFG_SLICE2, 15);
        write_cfg(CFG_BOOST, 127);
        test_random(60, 15);
        write_cfg(CFG_SLICE0, 1);
        write_cfg(CFG_SLICE1, 1);
        write_cfg(CFG_SLICE2, 1);
        write_cfg(CFG_BOOST, 1);
        sink_stall_en = 1'b0;
        test_random(60, 5);
        sink_stall_en = 1'b1;
        write_cfg(CFG_SLICE0, $urandom_range(1, 15));
        write_cfg(CFG_SLICE1, $urandom_range(1, 15));
        write_cfg(CFG_SLICE2, $urandom_range(1, 15));
        write_cfg(CFG_BOOST, $urandom_range(1, 127));
        test_full_queue();
        write_cfg(CFG_SLICE2, 3);
        write_cfg(CFG_BOOST, 10);
        test_random(40, 11);
        drain();
        if (errors == 0) $display("three_level_feedback_scheduler: match");
        else $display("three_level_feedback_scheduler: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tlfs_pkg.sv
hdl/tlfs_cell.sv
hdl/tlfs_queue.sv
hdl/three_level_feedback_scheduler.sv
test/tb_three_level_feedback_scheduler.sv
